// ----- rtl/fcte_pkg.sv -----
// Shared types, codes and constants of the allocation table chain engine.
package fcte_pkg;

    localparam int ENTRIES_DEF = 4096;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 24;

    localparam logic [15:0] USED_BIT  = 16'h8000;
    localparam logic [15:0] LINK_MASK = 16'h7FFF;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_READ   = 3'd1,
        OP_COUNT  = 3'd2,
        OP_NTH    = 3'd3,
        OP_LAST   = 3'd4,
        OP_FREE   = 3'd5,
        OP_LINK   = 3'd6,
        OP_APPEND = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_CAPTURE,
        A_WR_LOAD,
        A_RD_IDX,
        A_WR_LINK,
        A_RD_TGT,
        A_WR_TGT,
        A_WALK,
        A_NTH,
        A_SCAN0,
        A_SCAN,
        A_AWR_CUR,
        A_ARD_NXT,
        A_AWR_NXT
    } action_t;

    typedef enum logic [2:0] {
        R_ZERO,
        R_DATA,
        R_KPLUS1,
        R_ENTRIES,
        R_CUR,
        R_NXT,
        R_LINK,
        R_IDX
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RDATA,
        S_WALK,
        S_NTH,
        S_SCAN,
        S_AWCUR,
        S_ARDNXT,
        S_AWNXT,
        S_LRD,
        S_LWR,
        S_OUT
    } state_t;

    typedef struct packed {
        action_t  action;
        logic     res_load;
        res_sel_t res_sel;
        status_t  res_st;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic used;
        logic link_zero;
        logic dvalid;
        logic k_zero;
        logic k_max;
        logic n_one;
        logic cnt_zero;
        logic out_busy;
    } dp_flags_t;

endpackage

// ----- rtl/fcte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fcte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/fcte_ctrl.sv -----
// Controller state machine sequencing table accesses for each operation.
module fcte_ctrl
    import fcte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_flags_t flags,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.action   = A_NONE;
        cmd.res_load = 1'b0;
        cmd.res_sel  = R_ZERO;
        cmd.res_st   = ST_OK;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.action = A_CAPTURE;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (flags.op)
                    OP_LOAD:
                    begin
                        cmd.action   = A_WR_LOAD;
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                    end
                    OP_READ:
                    begin
                        cmd.action = A_RD_IDX;
                        state_next = S_RDATA;
                    end
                    OP_NTH:
                    begin
                        if (flags.cnt_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = R_IDX;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            cmd.action = A_RD_IDX;
                            state_next = S_NTH;
                        end
                    end
                    OP_FREE:
                    begin
                        cmd.action = A_RD_IDX;
                        state_next = S_SCAN;
                    end
                    OP_LINK:
                    begin
                        cmd.action = A_WR_LINK;
                        state_next = S_LRD;
                    end
                    default:
                    begin
                        cmd.action = A_RD_IDX;
                        state_next = S_WALK;
                    end
                endcase
            end
            S_RDATA:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = R_DATA;
                state_next   = S_OUT;
            end
            S_WALK:
            begin
                if (flags.op == OP_COUNT && flags.k_zero && !flags.used)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_st   = ST_INVALID;
                    state_next   = S_OUT;
                end
                else if (flags.link_zero)
                begin
                    if (flags.op == OP_APPEND && !flags.cnt_zero)
                    begin
                        cmd.action = A_SCAN0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = (flags.op == OP_COUNT) ? R_KPLUS1 : R_CUR;
                        state_next   = S_OUT;
                    end
                end
                else if (flags.k_max)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_st   = ST_CORRUPT;
                    case (flags.op)
                        OP_COUNT:  cmd.res_sel = R_ENTRIES;
                        OP_LAST:   cmd.res_sel = R_CUR;
                        default:   cmd.res_sel = R_ZERO;
                    endcase
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.action = A_WALK;
                end
            end
            S_NTH:
            begin
                if (flags.n_one)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = R_LINK;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.action = A_NTH;
                end
            end
            S_SCAN:
            begin
                if (!flags.dvalid)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_st   = ST_FULL;
                    cmd.res_sel  = (flags.op == OP_APPEND) ? R_CUR : R_ZERO;
                    state_next   = S_OUT;
                end
                else if (!flags.used)
                begin
                    if (flags.op == OP_APPEND)
                    begin
                        state_next = S_AWCUR;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = R_NXT;
                        state_next   = S_OUT;
                    end
                end
                else
                begin
                    cmd.action = A_SCAN;
                end
            end
            S_AWCUR:
            begin
                cmd.action = A_AWR_CUR;
                state_next = S_ARDNXT;
            end
            S_ARDNXT:
            begin
                cmd.action = A_ARD_NXT;
                state_next = S_AWNXT;
            end
            S_AWNXT:
            begin
                cmd.action = A_AWR_NXT;
                if (flags.n_one)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = R_NXT;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_LRD:
            begin
                cmd.action = A_RD_TGT;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                cmd.action   = A_WR_TGT;
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!flags.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !flags.out_busy)
        else $error("result transaction loaded over a pending one");
    a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> ($past(state_reg) == S_START || $past(state_reg) == S_WALK))
        else $error("walk entered from an unexpected state");
    a_append_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AWCUR) |-> (flags.op == OP_APPEND))
        else $error("append link step outside an append");
`endif

endmodule

// ----- rtl/fcte_dp.sv -----
// Datapath: operand registers, chain and scan pointers, table RAM, result registers.
module fcte_dp
    import fcte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output dp_flags_t        flags,
    input  logic [IN_W-1:0]  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int KW = $clog2(ENTRIES) + 1;

    op_t          op_reg;
    logic [11:0]  idx_reg;
    logic [15:0]  val_reg;
    logic [11:0]  cnt_reg;
    logic [14:0]  cur_reg;
    logic [15:0]  nxt_reg;
    logic [KW-1:0] k_reg;
    logic [11:0]  n_reg;
    logic         dvalid_reg;
    logic [15:0]  res_reg;
    status_t      st_reg;
    logic [15:0]  out_res_reg;
    status_t      out_st_reg;
    logic         out_valid_reg;

    logic [15:0]  ram_rdata;
    logic [15:0]  data;
    logic [14:0]  link;
    logic [15:0]  nxt_inc;
    logic         rd_en;
    logic [15:0]  rd_addr;
    logic         wr_req;
    logic         wr_en;
    logic [15:0]  wr_addr;
    logic [15:0]  wr_data;
    logic [15:0]  res_mux;

    function automatic logic addr_ok(input logic [15:0] a);
        return {1'b0, a} < 17'(ENTRIES);
    endfunction

    assign data    = dvalid_reg ? ram_rdata : 16'h0000;
    assign link    = 15'(data & LINK_MASK);
    assign nxt_inc = nxt_reg + 16'd1;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = 16'h0000;
        case (cmd.action)
            A_RD_IDX:  rd_addr = {4'h0, idx_reg};
            A_RD_TGT:  rd_addr = val_reg & LINK_MASK;
            A_WALK:    rd_addr = {1'b0, link};
            A_NTH:     rd_addr = {1'b0, link};
            A_SCAN0:   rd_addr = 16'h0000;
            A_SCAN:    rd_addr = nxt_inc;
            A_ARD_NXT: rd_addr = nxt_reg;
            A_AWR_NXT: rd_addr = nxt_inc;
            default:   rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_req  = 1'b1;
        wr_addr = 16'h0000;
        wr_data = 16'h0000;
        case (cmd.action)
            A_WR_LOAD:
            begin
                wr_addr = {4'h0, idx_reg};
                wr_data = val_reg;
            end
            A_WR_LINK:
            begin
                wr_addr = {4'h0, idx_reg};
                wr_data = val_reg | USED_BIT;
            end
            A_WR_TGT:
            begin
                wr_addr = val_reg & LINK_MASK;
                wr_data = data | USED_BIT;
            end
            A_AWR_CUR:
            begin
                wr_addr = {1'b0, cur_reg};
                wr_data = (nxt_reg & LINK_MASK) | USED_BIT;
            end
            A_AWR_NXT:
            begin
                wr_addr = nxt_reg;
                wr_data = data | USED_BIT;
            end
            default:
            begin
                wr_req = 1'b0;
            end
        endcase
    end

    assign wr_en = wr_req && addr_ok(wr_addr);

    fcte_ram #(
        .WIDTH (16),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            dvalid_reg <= addr_ok(rd_addr);
        end
        case (cmd.action)
            A_CAPTURE:
            begin
                op_reg  <= op_t'(in_data[2:0]);
                idx_reg <= in_data[14:3];
                val_reg <= in_data[30:15];
                cnt_reg <= in_data[42:31];
            end
            A_RD_IDX:
            begin
                cur_reg <= {3'b000, idx_reg};
                nxt_reg <= {4'h0, idx_reg};
                k_reg   <= '0;
                n_reg   <= cnt_reg;
            end
            A_WALK:
            begin
                cur_reg <= link;
                k_reg   <= k_reg + KW'(1);
            end
            A_NTH:
            begin
                cur_reg <= link;
                n_reg   <= n_reg - 12'd1;
            end
            A_SCAN0:
            begin
                nxt_reg <= 16'h0000;
            end
            A_SCAN:
            begin
                nxt_reg <= nxt_inc;
            end
            A_AWR_NXT:
            begin
                cur_reg <= nxt_reg[14:0];
                nxt_reg <= nxt_inc;
                n_reg   <= n_reg - 12'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (cmd.res_sel)
            R_DATA:    res_mux = data;
            R_KPLUS1:  res_mux = 16'(k_reg + KW'(1));
            R_ENTRIES: res_mux = 16'(ENTRIES);
            R_CUR:     res_mux = {1'b0, cur_reg};
            R_NXT:     res_mux = nxt_reg;
            R_LINK:    res_mux = {1'b0, link};
            R_IDX:     res_mux = {4'h0, idx_reg};
            default:   res_mux = 16'h0000;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_mux;
            st_reg  <= cmd.res_st;
        end
        if (cmd.out_load)
        begin
            out_res_reg <= res_reg;
            out_st_reg  <= st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {6'b000000, out_st_reg, out_res_reg};

    assign flags.op        = op_reg;
    assign flags.used      = data[15];
    assign flags.link_zero = (link == 15'h0000);
    assign flags.dvalid    = dvalid_reg;
    assign flags.k_zero    = (k_reg == '0);
    assign flags.k_max     = (k_reg == KW'(ENTRIES - 1));
    assign flags.n_one     = (n_reg == 12'd1);
    assign flags.cnt_zero  = (cnt_reg == 12'd0);
    assign flags.out_busy  = out_valid_reg && !out_ready;

`ifndef ASSERT_OFF
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} < 17'(ENTRIES)))
        else $error("table write outside the table");
    a_k_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.action == A_WALK) |-> (k_reg < KW'(ENTRIES - 1)))
        else $error("walk stepped past the link cap");
    a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.action == A_SCAN || cmd.action == A_AWR_NXT) |-> (nxt_reg < 16'(ENTRIES)))
        else $error("scan advanced from beyond the table");
    a_nth_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.action == A_NTH) |-> (n_reg > 12'd1))
        else $error("link follow count underflow");
`endif

endmodule

// ----- rtl/fat_chain_table_engine.sv -----
// Top level of the allocation table chain engine: controller plus datapath.
//
//   channel | direction | tdata fields (low bit up)                      | tuser/tlast
//   s_axis  | in        | operation[2:0] index[14:3] value[30:15] count[42:31] | none
//   m_axis  | out       | result[15:0] status[17:16]                      | none
//
// One operation at a time; the table RAM gives one read and one write per cycle.
// Count, last and nth walk the chain link by link; find free scans entries in order.
// Ready rises with result valid.
// Append walks to the chain end, then per sector scans for a free entry and links it.
// Reset clears the controller and the result valid; the table is undefined until written.
// A stalled result holds in its output register; the next transaction is still taken.
module fat_chain_table_engine
    import fcte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // operation, index, value, count
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // result, status
);

    cmd_t      cmd;
    dp_flags_t flags;

    fcte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    fcte_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .flags     (flags),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- test/tb_fat_chain_table_engine.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the allocation table chain engine against a built-in table predictor.
module tb_fat_chain_table_engine;
    import fcte_pkg::*;

    localparam int TABLE_SIZE  = ENTRIES_DEF;
    localparam int IDLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES = 64;
    localparam int RANDOM_CMDS = 400;

    typedef struct {
        op_t         op;
        logic [11:0] index;
        logic [15:0] value;
        logic [11:0] count;
        bit          drain;
    } fat_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] result;
    } fat_reply_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [15:0] table_mirror [TABLE_SIZE];
    fat_cmd_t    cmd_queue[$];
    fat_reply_t  reply_queue[$];
    fat_cmd_t    cmd_on_bus;
    fat_reply_t  seen_reply;
    fat_reply_t  due_reply;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_phase = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fat_chain_table_engine #(
        .ENTRIES (TABLE_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [15:0] entry_rd(int unsigned i);
        if (i >= TABLE_SIZE)
            return 16'h0000;
        return table_mirror[i];
    endfunction

    function automatic void entry_wr(int unsigned i, logic [15:0] v);
        if (i < TABLE_SIZE)
            table_mirror[i] = v;
    endfunction

    function automatic void link_sector(int unsigned at, logic [15:0] next);
        entry_wr(at, next | USED_BIT);
        entry_wr(next & LINK_MASK, entry_rd(next & LINK_MASK) | USED_BIT);
    endfunction

    function automatic bit walk_chain(int unsigned start, output int unsigned last,
                                      output int unsigned hops);
        int unsigned cur;
        cur  = start;
        hops = 0;
        while ((entry_rd(cur) & LINK_MASK) != 0)
        begin
            if (hops >= TABLE_SIZE - 1)
            begin
                last = cur;
                return 1'b0;
            end
            cur = entry_rd(cur) & LINK_MASK;
            hops++;
        end
        last = cur;
        return 1'b1;
    endfunction

    function automatic bit first_free(int unsigned from, output int unsigned found);
        found = 0;
        for (int unsigned i = from; i < TABLE_SIZE; i++)
        begin
            if ((entry_rd(i) & USED_BIT) == 0)
            begin
                found = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic fat_reply_t predict_reply(fat_cmd_t c);
        fat_reply_t  r;
        int unsigned last;
        int unsigned hops;
        int unsigned nxt;
        r.result = '0;
        r.status = ST_OK;
        case (c.op)
            OP_LOAD:
                entry_wr(c.index, c.value);
            OP_READ:
                r.result = entry_rd(c.index);
            OP_COUNT:
            begin
                if ((entry_rd(c.index) & USED_BIT) == 0)
                    r.status = ST_INVALID;
                else if (walk_chain(c.index, last, hops))
                    r.result = 16'(hops + 1);
                else
                begin
                    r.result = 16'(TABLE_SIZE);
                    r.status = ST_CORRUPT;
                end
            end
            OP_NTH:
            begin
                last = c.index;
                repeat (c.count)
                    last = entry_rd(last) & LINK_MASK;
                r.result = 16'(last);
            end
            OP_LAST:
            begin
                if (!walk_chain(c.index, last, hops))
                    r.status = ST_CORRUPT;
                r.result = 16'(last);
            end
            OP_FREE:
            begin
                if (first_free(c.index, nxt))
                    r.result = 16'(nxt);
                else
                    r.status = ST_FULL;
            end
            OP_LINK:
                link_sector(c.index, c.value);
            default:
            begin
                if (!walk_chain(c.index, last, hops))
                    r.status = ST_CORRUPT;
                else
                begin
                    nxt = 0;
                    for (int unsigned k = 0; k < c.count; k++)
                    begin
                        if (!first_free(nxt, nxt))
                        begin
                            r.status = ST_FULL;
                            break;
                        end
                        link_sector(last, 16'(nxt));
                        last = nxt;
                    end
                    r.result = 16'(last);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] random_entry();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'h0000;
            4, 5, 6:    return USED_BIT;
            7, 8:       return USED_BIT | 16'($urandom_range(1, TABLE_SIZE - 1));
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic queue_cmd(op_t op, int unsigned index, logic [15:0] value,
                             int unsigned count, bit drain);
        fat_cmd_t c;
        c.op    = op;
        c.index = 12'(index);
        c.value = value;
        c.count = 12'(count);
        c.drain = drain;
        cmd_queue.push_back(c);
    endtask

    task automatic queue_table_fill();
        for (int i = 0; i < TABLE_SIZE; i++)
            queue_cmd(OP_LOAD, i, random_entry(), $urandom_range(0, TABLE_SIZE - 1), i == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                reply_queue.push_back(predict_reply(cmd_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].drain && reply_queue.size() > 0))
                begin
                    cmd_on_bus = cmd_queue.pop_front();
                    s_axis_tdata  <= IN_W'({cmd_on_bus.count, cmd_on_bus.value,
                                            cmd_on_bus.index, cmd_on_bus.op});
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase++;
            case ((stall_phase >> 9) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (stall_phase % 5) != 0;
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_reply = fat_reply_t'(m_axis_tdata[17:0]);
                if (reply_queue.size() == 0)
                    report_mismatch("result with nothing pending", 0, seen_reply);
                else
                begin
                    due_reply = reply_queue.pop_front();
                    if (seen_reply.result != due_reply.result)
                        report_mismatch("result", due_reply.result, seen_reply.result);
                    if (seen_reply.status != due_reply.status)
                        report_mismatch("status", due_reply.status, seen_reply.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned heads[$];
        int unsigned pick;
        fat_cmd_t    c;

        queue_table_fill();

        queue_cmd(OP_LOAD, 0, 16'hFFFF, 0, 1'b1);
        queue_cmd(OP_LOAD, TABLE_SIZE - 1, 16'h0000, 12'hFFF, 1'b0);
        queue_cmd(OP_READ, 0, 16'h0000, 0, 1'b0);
        queue_cmd(OP_READ, TABLE_SIZE - 1, 16'hFFFF, 12'hFFF, 1'b0);
        queue_cmd(OP_LOAD, 5, USED_BIT | 16'd6, 0, 1'b0);
        queue_cmd(OP_LOAD, 6, USED_BIT | 16'd7, 0, 1'b0);
        queue_cmd(OP_LOAD, 7, USED_BIT, 0, 1'b0);
        queue_cmd(OP_LOAD, 8, 16'h0000, 0, 1'b0);
        queue_cmd(OP_COUNT, 5, 16'h0000, 0, 1'b0);
        queue_cmd(OP_COUNT, TABLE_SIZE - 1, 16'h0000, 0, 1'b0);
        queue_cmd(OP_LAST, 5, 16'h0000, 0, 1'b0);
        queue_cmd(OP_NTH, 5, 16'h0000, 0, 1'b0);
        queue_cmd(OP_NTH, 5, 16'h0000, 2, 1'b0);
        queue_cmd(OP_NTH, 5, 16'h0000, 12'hFFF, 1'b0);
        queue_cmd(OP_LOAD, 10, USED_BIT | 16'd11, 0, 1'b0);
        queue_cmd(OP_LOAD, 11, USED_BIT | 16'd10, 0, 1'b0);
        queue_cmd(OP_COUNT, 10, 16'h0000, 0, 1'b0);
        queue_cmd(OP_LAST, 10, 16'h0000, 0, 1'b0);
        queue_cmd(OP_APPEND, 10, 16'h0000, 3, 1'b0);
        queue_cmd(OP_LOAD, 11, USED_BIT, 0, 1'b0);
        queue_cmd(OP_FREE, TABLE_SIZE - 1, 16'h0000, 0, 1'b0);
        queue_cmd(OP_LINK, TABLE_SIZE - 1, 16'hFFFF, 0, 1'b0);
        queue_cmd(OP_FREE, TABLE_SIZE - 1, 16'h0000, 0, 1'b0);
        queue_cmd(OP_LINK, 7, 16'd8, 0, 1'b0);
        queue_cmd(OP_APPEND, 5, 16'h0000, 0, 1'b0);
        queue_cmd(OP_APPEND, 5, 16'h0000, 2, 1'b0);
        queue_cmd(OP_APPEND, 5, 16'h0000, 12'hFFF, 1'b0);
        queue_cmd(OP_COUNT, 5, 16'h0000, 0, 1'b0);

        queue_table_fill();

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (heads.size() > 0 && $urandom_range(0, 9) < 6)
                pick = heads[$urandom_range(0, heads.size() - 1)];
            else
                pick = $urandom_range(0, TABLE_SIZE - 1);
            c.op    = OP_READ;
            c.index = 12'(pick);
            c.value = 16'($urandom);
            c.count = 0;
            c.drain = (n % 50 == 0);
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    c.op    = OP_LOAD;
                    c.value = random_entry();
                end
                2, 3:
                    c.op = OP_READ;
                4, 5, 6:
                    c.op = OP_COUNT;
                7, 8:
                begin
                    c.op    = OP_NTH;
                    c.count = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                          : 12'($urandom_range(0, 15));
                end
                9, 10, 11:
                    c.op = OP_LAST;
                12, 13, 14:
                    c.op = OP_FREE;
                15, 16:
                begin
                    c.op = OP_LINK;
                    if ($urandom_range(0, 9) < 7)
                        c.value = 16'($urandom_range(1, TABLE_SIZE - 1));
                    heads.push_back(pick);
                end
                default:
                begin
                    c.op    = OP_APPEND;
                    c.count = 12'($urandom_range(0, 6));
                    heads.push_back(pick);
                end
            endcase
            if (heads.size() > 16)
                void'(heads.pop_front());
            cmd_queue.push_back(c);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || s_axis_tvalid || reply_queue.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && reply_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
